@@ rtl/core/handheld_memory_map_unit_core_macros.svh @@
// Assertion macros used by the checker file of the memory map unit.
`ifndef HANDHELD_MEMORY_MAP_UNIT_CORE_MACROS_SVH
`define HANDHELD_MEMORY_MAP_UNIT_CORE_MACROS_SVH

// Property checked while reset is low.
`define HMMU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define HMMU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/hmmu_pkg.sv @@
// Package: constants, codes, control/status types and decode helpers of the memory map unit.
package hmmu_pkg;

  localparam int BOOT_SIZE  = 256;
  localparam int DMA_LENGTH = 160;
  localparam int BOOT_AW    = (BOOT_SIZE > 1) ? $clog2(BOOT_SIZE) : 1;
  localparam int DMA_IW     = (DMA_LENGTH > 1) ? $clog2(DMA_LENGTH) : 1;
  localparam logic [15:0] BOOT_LIMIT = 16'(BOOT_SIZE);

  // bus addresses
  localparam logic [15:0] ADDR_BOOT_EXIT  = 16'h0100;
  localparam logic [15:0] ADDR_VRAM       = 16'h8000;
  localparam logic [15:0] ADDR_ECHO_LO    = 16'hE000;
  localparam logic [15:0] ECHO_OFFSET     = 16'h2000;
  localparam logic [15:0] ADDR_OAM        = 16'hFE00;
  localparam logic [15:0] ADDR_UNUSED_LO  = 16'hFEA0;
  localparam logic [15:0] ADDR_UNUSED_HI  = 16'hFEFF;
  localparam logic [15:0] ADDR_JOYP       = 16'hFF00;
  localparam logic [15:0] ADDR_SOUND_LO   = 16'hFF10;
  localparam logic [15:0] ADDR_SOUND_HI   = 16'hFF26;
  localparam logic [15:0] ADDR_LY         = 16'hFF44;
  localparam logic [15:0] ADDR_DMA        = 16'hFF46;
  localparam logic [7:0]  BYTE_OPEN       = 8'hFF;

  // bus commands
  localparam logic [2:0] CMD_RD_BYTE   = 3'd0;
  localparam logic [2:0] CMD_WR_BYTE   = 3'd1;
  localparam logic [2:0] CMD_RD_WORD   = 3'd2;
  localparam logic [2:0] CMD_WR_WORD   = 3'd3;
  localparam logic [2:0] CMD_BOOT_LOAD = 3'd4;

  // write classes
  localparam logic [2:0] WR_DROP  = 3'd0;
  localparam logic [2:0] WR_PLAIN = 3'd1;
  localparam logic [2:0] WR_ECHO  = 3'd2;
  localparam logic [2:0] WR_JOYP  = 3'd3;
  localparam logic [2:0] WR_DMA   = 3'd4;

  typedef struct packed {
    logic latch;
    logic byte_next;
    logic issue;
    logic issue_dma;
    logic capture;
    logic wr_cur;
    logic wr_echo;
    logic wr_dma;
    logic boot_wr;
    logic strobe_set;
    logic dma_clr;
    logic dma_inc;
    logic sweep_wr;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       byte_sel;
    logic [2:0] wr_cls;
    logic       dma_last;
    logic       sweep_last;
    logic       out_free;
  } sts_t;

  function automatic logic [7:0] io_default(logic [15:0] a);
    logic [7:0] v;
    unique case (a)
      16'hFF00: v = 8'hFF;
      16'hFF04: v = 8'hAF;
      16'hFF07: v = 8'hF8;
      16'hFF0F: v = 8'hE0;
      16'hFF10: v = 8'h80;
      16'hFF11: v = 8'hBF;
      16'hFF12: v = 8'hF3;
      16'hFF14: v = 8'hBF;
      16'hFF16: v = 8'h3F;
      16'hFF19: v = 8'hBF;
      16'hFF1A: v = 8'h7F;
      16'hFF1B: v = 8'hFF;
      16'hFF1C: v = 8'h9F;
      16'hFF1E: v = 8'hBF;
      16'hFF1F: v = 8'hFF;
      16'hFF20: v = 8'hFF;
      16'hFF23: v = 8'hBF;
      16'hFF24: v = 8'h77;
      16'hFF25: v = 8'hF3;
      16'hFF26: v = 8'hF1;
      16'hFF40: v = 8'h91;
      16'hFF47: v = 8'hFC;
      16'hFF48: v = 8'hFF;
      16'hFF49: v = 8'hFF;
      default:  v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic in_unused(logic [15:0] a);
    return (a >= ADDR_UNUSED_LO) && (a <= ADDR_UNUSED_HI);
  endfunction

  function automatic logic rd_is_open(logic [15:0] a);
    return ((a >= ADDR_SOUND_LO) && (a <= ADDR_SOUND_HI)) || in_unused(a);
  endfunction

  function automatic logic [2:0] wr_class(logic [15:0] a);
    logic [2:0] c;
    priority if (a < ADDR_VRAM || in_unused(a) || a == ADDR_LY) c = WR_DROP;
    else if (a >= ADDR_ECHO_LO && a < ADDR_OAM)                 c = WR_ECHO;
    else if (a == ADDR_JOYP)                                    c = WR_JOYP;
    else if (a == ADDR_DMA)                                     c = WR_DMA;
    else                                                        c = WR_PLAIN;
    return c;
  endfunction

endpackage

@@ rtl/core/hmmu_if.sv @@
// Request and response channel interfaces of the memory map unit.
interface hmmu_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] bus_address;
  logic [15:0] write_data;
  logic [7:0]  joypad_state;

  modport source (output valid, command, bus_address, write_data, joypad_state,
                  input ready);
  modport sink   (input valid, command, bus_address, write_data, joypad_state,
                  output ready);
endinterface

interface hmmu_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        joypad_strobe;
  logic [7:0]  joypad_value;
  logic        boot_exited;

  modport source (output valid, read_data, joypad_strobe, joypad_value, boot_exited,
                  input ready);
  modport sink   (input valid, read_data, joypad_strobe, joypad_value, boot_exited,
                  output ready);
endinterface

@@ rtl/core/hmmu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hmmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/hmmu_ctrl.sv @@
// Controller: sequences sweep, byte reads, writes, echo, boot loads and DMA copy steps.
module hmmu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2:0]        in_command,
  output logic              in_ready,
  input  hmmu_pkg::sts_t    sts,
  output hmmu_pkg::ctl_t    ctl
);

  localparam logic [3:0] S_SWEEP    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_BOOT     = 4'd2;
  localparam logic [3:0] S_RD_ISSUE = 4'd3;
  localparam logic [3:0] S_RD_DATA  = 4'd4;
  localparam logic [3:0] S_WR       = 4'd5;
  localparam logic [3:0] S_ECHO     = 4'd6;
  localparam logic [3:0] S_DMA_RD   = 4'd7;
  localparam logic [3:0] S_DMA_WR   = 4'd8;
  localparam logic [3:0] S_WR_STORE = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       wr_more;
  logic       rd_more;

  assign wr_more  = (sts.cmd == hmmu_pkg::CMD_WR_WORD) && !sts.byte_sel;
  assign rd_more  = (sts.cmd == hmmu_pkg::CMD_RD_WORD) && !sts.byte_sel;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        ctl.sweep_wr = 1'b1;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          unique case (in_command)
            hmmu_pkg::CMD_RD_BYTE,
            hmmu_pkg::CMD_RD_WORD:   state_next = S_RD_ISSUE;
            hmmu_pkg::CMD_WR_BYTE,
            hmmu_pkg::CMD_WR_WORD:   state_next = S_WR;
            hmmu_pkg::CMD_BOOT_LOAD: state_next = S_BOOT;
            default:                 state_next = S_DONE;
          endcase
        end
      end
      S_BOOT: begin
        ctl.boot_wr = 1'b1;
        state_next  = S_DONE;
      end
      S_RD_ISSUE: begin
        ctl.issue  = 1'b1;
        state_next = S_RD_DATA;
      end
      S_RD_DATA: begin
        ctl.capture = 1'b1;
        if (rd_more) begin
          ctl.byte_next = 1'b1;
          state_next    = S_RD_ISSUE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WR: begin
        unique case (sts.wr_cls)
          hmmu_pkg::WR_ECHO: begin
            ctl.wr_cur = 1'b1;
            state_next = S_ECHO;
          end
          hmmu_pkg::WR_DMA: begin
            ctl.dma_clr = 1'b1;
            state_next  = S_DMA_RD;
          end
          default: begin
            ctl.wr_cur     = (sts.wr_cls != hmmu_pkg::WR_DROP);
            ctl.strobe_set = (sts.wr_cls == hmmu_pkg::WR_JOYP);
            ctl.byte_next  = wr_more;
            state_next     = wr_more ? S_WR : S_DONE;
          end
        endcase
      end
      S_ECHO: begin
        ctl.wr_echo   = 1'b1;
        ctl.byte_next = wr_more;
        state_next    = wr_more ? S_WR : S_DONE;
      end
      S_DMA_RD: begin
        ctl.issue     = 1'b1;
        ctl.issue_dma = 1'b1;
        state_next    = S_DMA_WR;
      end
      S_DMA_WR: begin
        ctl.wr_dma = 1'b1;
        if (sts.dma_last) begin
          state_next = S_WR_STORE;
        end else begin
          ctl.dma_inc = 1'b1;
          state_next  = S_DMA_RD;
        end
      end
      S_WR_STORE: begin
        ctl.wr_cur    = 1'b1;
        ctl.byte_next = wr_more;
        state_next    = wr_more ? S_WR : S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_SWEEP;
    endcase
  end

endmodule

@@ rtl/core/hmmu_datapath.sv @@
// Datapath: item registers, address decode, main and boot RAMs, result register.
module hmmu_datapath (
  input  logic              clk,
  input  logic              rst,
  input  hmmu_pkg::ctl_t    ctl,
  output hmmu_pkg::sts_t    sts,
  input  logic [2:0]        command,
  input  logic [15:0]       bus_address,
  input  logic [15:0]       write_data,
  input  logic [7:0]        joypad_state,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       read_data,
  output logic              joypad_strobe,
  output logic [7:0]        joypad_value,
  output logic              boot_exited
);

  logic [2:0]                    cmd_q;
  logic [15:0]                   addr_q;
  logic [15:0]                   data_q;
  logic [7:0]                    pad_q;
  logic                          byte_sel;
  logic                          overlay;
  logic [hmmu_pkg::DMA_IW-1:0]   dma_idx;
  logic [15:0]                   sweep;
  logic                          cls_boot;
  logic                          cls_pad;
  logic                          cls_open;
  logic [7:0]                    rd_lo;
  logic [7:0]                    rd_hi;
  logic                          strobe;
  logic [7:0]                    joy_val;
  logic                          exited;

  logic [15:0] cur;
  logic [7:0]  wbyte;
  logic [15:0] dma_src;
  logic [15:0] dma_dst;
  logic [15:0] raddr;
  logic [7:0]  main_q;
  logic [7:0]  boot_q;
  logic [7:0]  rbyte;

  logic        main_we;
  logic [15:0] main_waddr;
  logic [7:0]  main_wdata;
  logic                        boot_we;
  logic [hmmu_pkg::BOOT_AW-1:0] boot_waddr;
  logic [7:0]                  boot_wdata;

  assign cur     = byte_sel ? addr_q + 16'd1 : addr_q;
  assign wbyte   = byte_sel ? data_q[15:8] : data_q[7:0];
  assign dma_src = {wbyte, 8'(dma_idx)};
  assign dma_dst = {hmmu_pkg::ADDR_OAM[15:8], 8'(dma_idx)};
  assign raddr   = ctl.issue_dma ? dma_src : cur;

  always_comb begin
    priority if (cls_boot) rbyte = boot_q;
    else if (cls_pad)      rbyte = pad_q;
    else if (cls_open)     rbyte = hmmu_pkg::BYTE_OPEN;
    else                   rbyte = main_q;
  end

  assign main_we = ctl.sweep_wr | ctl.wr_cur | ctl.wr_echo | ctl.wr_dma;

  always_comb begin
    priority if (ctl.sweep_wr) begin
      main_waddr = sweep;
      main_wdata = hmmu_pkg::io_default(sweep);
    end else if (ctl.wr_dma) begin
      main_waddr = dma_dst;
      main_wdata = rbyte;
    end else if (ctl.wr_echo) begin
      main_waddr = cur - hmmu_pkg::ECHO_OFFSET;
      main_wdata = wbyte;
    end else begin
      main_waddr = cur;
      main_wdata = wbyte;
    end
  end

  // boot ROM is zeroed by the same sweep
  assign boot_we    = (ctl.sweep_wr && (sweep < hmmu_pkg::BOOT_LIMIT))
                    || (ctl.boot_wr && (addr_q < hmmu_pkg::BOOT_LIMIT));
  assign boot_waddr = ctl.sweep_wr ? sweep[hmmu_pkg::BOOT_AW-1:0]
                                   : addr_q[hmmu_pkg::BOOT_AW-1:0];
  assign boot_wdata = ctl.sweep_wr ? 8'h00 : data_q[7:0];

  hmmu_ram #(.WIDTH(8), .DEPTH(65536)) u_main_ram (
    .clk   (clk),
    .we    (main_we),
    .waddr (main_waddr),
    .wdata (main_wdata),
    .raddr (raddr),
    .rdata (main_q)
  );

  hmmu_ram #(.WIDTH(8), .DEPTH(hmmu_pkg::BOOT_SIZE)) u_boot_ram (
    .clk   (clk),
    .we    (boot_we),
    .waddr (boot_waddr),
    .wdata (boot_wdata),
    .raddr (raddr[hmmu_pkg::BOOT_AW-1:0]),
    .rdata (boot_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      overlay   <= 1'b0;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.sweep_wr) sweep <= sweep + 16'd1;
      if (ctl.boot_wr) begin
        overlay <= 1'b1;
      end else if (ctl.issue && overlay && raddr == hmmu_pkg::ADDR_BOOT_EXIT) begin
        overlay <= 1'b0;
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q    <= command;
      addr_q   <= bus_address;
      data_q   <= write_data;
      pad_q    <= joypad_state;
      byte_sel <= 1'b0;
      rd_lo    <= '0;
      rd_hi    <= '0;
      strobe   <= 1'b0;
      joy_val  <= '0;
      exited   <= 1'b0;
    end else begin
      if (ctl.byte_next) byte_sel <= 1'b1;
      if (ctl.capture) begin
        if (byte_sel) rd_hi <= rbyte;
        else          rd_lo <= rbyte;
      end
      if (ctl.strobe_set) begin
        strobe  <= 1'b1;
        joy_val <= wbyte;
      end
      if (ctl.issue && overlay && raddr == hmmu_pkg::ADDR_BOOT_EXIT) exited <= 1'b1;
    end
    if (ctl.issue) begin
      cls_boot <= overlay && (raddr < hmmu_pkg::BOOT_LIMIT);
      cls_pad  <= (raddr == hmmu_pkg::ADDR_JOYP);
      cls_open <= hmmu_pkg::rd_is_open(raddr);
    end
    if (ctl.dma_clr) begin
      dma_idx <= '0;
    end else if (ctl.dma_inc) begin
      dma_idx <= dma_idx + hmmu_pkg::DMA_IW'(1);
    end
    if (ctl.out_load) begin
      read_data     <= {rd_hi, rd_lo};
      joypad_strobe <= strobe;
      joypad_value  <= joy_val;
      boot_exited   <= exited;
    end
  end

  assign sts.cmd        = cmd_q;
  assign sts.byte_sel   = byte_sel;
  assign sts.wr_cls     = hmmu_pkg::wr_class(cur);
  assign sts.dma_last   = (dma_idx == hmmu_pkg::DMA_IW'(hmmu_pkg::DMA_LENGTH - 1));
  assign sts.sweep_last = &sweep;
  assign sts.out_free   = !out_valid || out_ready;

endmodule

@@ rtl/core/handheld_memory_map_unit_core.sv @@
// Top level of the handheld memory map unit: controller plus datapath.
//
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | command, bus_address, write_data, joypad_state
//  rsp     | out | valid/ready | read_data, joypad_strobe, joypad_value, boot_exited
//
// One item at a time; a word access handles its second byte after its first.
// An echo byte write stores the byte, then its mirror below the echo range.
// A write to the DMA register copies DMA_LENGTH bytes into OAM (one RAM read and
// one RAM write per copied byte on the single main memory), then stores the write.
// After reset a sweep over main memory loads its defaults and clears boot ROM;
// req.ready stays low meanwhile. A stalled rsp beat holds; one item may be taken
// while it waits, and that item finishes once the output register frees.
module handheld_memory_map_unit_core (
  input  logic       clk,
  input  logic       rst,
  hmmu_req_if.sink   req,
  hmmu_rsp_if.source rsp
);

  hmmu_pkg::ctl_t ctl;
  hmmu_pkg::sts_t sts;

  hmmu_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_ready   (req.ready),
    .sts        (sts),
    .ctl        (ctl)
  );

  hmmu_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .command       (req.command),
    .bus_address   (req.bus_address),
    .write_data    (req.write_data),
    .joypad_state  (req.joypad_state),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .read_data     (rsp.read_data),
    .joypad_strobe (rsp.joypad_strobe),
    .joypad_value  (rsp.joypad_value),
    .boot_exited   (rsp.boot_exited)
  );

endmodule

@@ rtl/core/hmmu_checker.sv @@
// Port-level checker for the memory map unit and its bind to the top level.
`include "handheld_memory_map_unit_core_macros.svh"

module hmmu_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] rsp_read_data,
  input logic        rsp_joypad_strobe,
  input logic [7:0]  rsp_joypad_value,
  input logic        rsp_boot_exited
);

  logic [25:0] rsp_payload;

  assign rsp_payload = {rsp_read_data, rsp_joypad_strobe, rsp_joypad_value, rsp_boot_exited};

  // stalled response beat keeps its contents
  `HMMU_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "rsp beat changed while stalled")

  // memory sweep follows reset, no request taken
  `HMMU_ASSERT_ALWAYS(a_sweep_after_rst, clk, rst |=> !req_ready, "req ready right after reset")

  // one item in flight: ready drops after a request beat
  `HMMU_ASSERT(a_one_item, clk, rst, req_valid && req_ready |=> !req_ready, "req ready after accept")

  // joypad value only accompanies a strobe
  `HMMU_ASSERT(a_joyp_value, clk, rst, rsp_valid && !rsp_joypad_strobe |-> rsp_joypad_value == 8'h00, "joypad value without strobe")

endmodule

bind handheld_memory_map_unit_core hmmu_checker u_hmmu_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_read_data     (rsp.read_data),
  .rsp_joypad_strobe (rsp.joypad_strobe),
  .rsp_joypad_value  (rsp.joypad_value),
  .rsp_boot_exited   (rsp.boot_exited)
);

@@ tb/tb_top.sv @@
// Testbench of the handheld memory map unit: directed table, random traffic, in-order beat checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam logic       TYPED = 1'b1;
  localparam logic       PRED  = 1'b0;

  localparam logic [15:0] DMA_REG = hmmu_pkg::ADDR_DMA;

  localparam int RAND_ITEMS = 1225;
  localparam int IDLE_PCT   = 22;
  localparam int CALM_LO    = 400;
  localparam int CALM_HI    = 650;
  localparam int HOLD_AT    = 500;
  localparam int HOLD_LEN   = 400;
  localparam int PAUSE_AT   = 900;
  localparam int DRAIN_WAIT = 40;
  // the clearing sweep after reset covers all of main memory with no beat
  localparam int QUIET_LIMIT = 200000;

  localparam logic [15:0] WRAM_BASES [4] = '{16'h8000, 16'h9FF0, 16'hC000, 16'hDDF0};
  localparam logic [15:0] ECHO_BASES [2] = '{16'hE000, 16'hFDF0};
  localparam logic [7:0]  DMA_PAGES  [8] = '{8'h00, 8'h01, 8'h80, 8'hC0,
                                             8'hDD, 8'hE0, 8'hFE, 8'hFF};

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] addr;
    logic [15:0] data;
    logic [7:0]  pad;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        joypad_strobe;
    logic [7:0]  joypad_value;
    logic        boot_exited;
  } beat_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] addr;
    logic [15:0] data;
    logic [7:0]  pad;
    logic        typed;
    logic [15:0] rd;
    logic        strb;
    logic [7:0]  jv;
    logic        ex;
  } dir_row_t;

  localparam int DIR_ROWS = 27;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{hmmu_pkg::CMD_RD_BYTE, 16'h0000, 16'h0000, 8'h00, TYPED, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_RD_BYTE, 16'hFF00, 16'hFFFF, 8'hA5, TYPED, 16'h00A5, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_RD_BYTE, 16'hFF40, 16'h0000, 8'hFF, TYPED, 16'h0091, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_RD_BYTE, 16'hFF10, 16'h0000, 8'h00, TYPED, 16'h00FF, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_RD_BYTE, 16'hFEA0, 16'h0000, 8'h00, TYPED, 16'h00FF, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_RD_WORD, 16'hFF26, 16'h0000, 8'h00, TYPED, 16'h00FF, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_WR_BYTE, 16'h0000, 16'hFFFF, 8'hFF, TYPED, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_WR_BYTE, 16'hFF44, 16'h0012, 8'h00, TYPED, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_WR_BYTE, 16'hFF00, 16'h5A3C, 8'h00, TYPED, 16'h0000, 1'b1, 8'h3C, 1'b0},
    '{hmmu_pkg::CMD_WR_WORD, 16'hFFFF, 16'hABCD, 8'h00, TYPED, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_RD_BYTE, 16'hFFFF, 16'h0000, 8'h00, TYPED, 16'h00CD, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_WR_WORD, 16'hE000, 16'h1234, 8'h00, TYPED, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_RD_WORD, 16'hC000, 16'h0000, 8'h00, TYPED, 16'h1234, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_WR_BYTE, 16'hC000, 16'h0099, 8'h00, TYPED, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_WR_BYTE, DMA_REG,  16'h00C0, 8'h00, PRED,  16'h0000, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_RD_WORD, 16'hFE00, 16'h0000, 8'h00, TYPED, 16'h1299, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_BOOT_LOAD, 16'h0000, 16'h003E, 8'h00, TYPED, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_BOOT_LOAD, 16'h00FF, 16'hFFC9, 8'h00, TYPED, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_BOOT_LOAD, 16'hFFFF, 16'h0055, 8'h00, TYPED, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_RD_BYTE, 16'h0000, 16'h0000, 8'h00, TYPED, 16'h003E, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_RD_WORD, 16'h00FF, 16'h0000, 8'h00, TYPED, 16'h00C9, 1'b0, 8'h00, 1'b1},
    '{hmmu_pkg::CMD_BOOT_LOAD, 16'h0005, 16'h0066, 8'h00, TYPED, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_WR_BYTE, DMA_REG,  16'h0000, 8'h00, PRED,  16'h0000, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_RD_BYTE, 16'hFE05, 16'h0000, 8'h00, TYPED, 16'h0066, 1'b0, 8'h00, 1'b0},
    '{hmmu_pkg::CMD_WR_BYTE, DMA_REG,  16'h0001, 8'h00, TYPED, 16'h0000, 1'b0, 8'h00, 1'b1},
    '{hmmu_pkg::CMD_RD_BYTE, 16'hFE00, 16'h0000, 8'h00, TYPED, 16'h0000, 1'b0, 8'h00, 1'b0},
    '{CMD_UNUSED_HI, 16'hFFFF, 16'hFFFF, 8'hFF, TYPED, 16'h0000, 1'b0, 8'h00, 1'b0}
  };

  logic clk;
  logic rst;

  hmmu_req_if req_ch ();
  hmmu_rsp_if rsp_ch ();

  handheld_memory_map_unit_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predictor state
  logic [7:0] mem_img  [0:65535];
  logic [7:0] boot_img [0:hmmu_pkg::BOOT_SIZE-1];
  logic       overlay_armed;
  logic       exit_seen;
  logic       strobe_seen;
  logic [7:0] strobe_val;
  logic [7:0] pad_now;

  beat_t results_due [$];
  int    mismatch_count = 0;
  int    sent_count = 0;

  function automatic logic [7:0] peek_bus(logic [15:0] a);
    if (overlay_armed) begin
      if (a < hmmu_pkg::BOOT_LIMIT) return boot_img[a[hmmu_pkg::BOOT_AW-1:0]];
      if (a == hmmu_pkg::ADDR_BOOT_EXIT) begin
        overlay_armed = 1'b0;
        exit_seen = 1'b1;
      end
    end
    if (a == hmmu_pkg::ADDR_JOYP) return pad_now;
    if (a >= hmmu_pkg::ADDR_SOUND_LO && a <= hmmu_pkg::ADDR_SOUND_HI) return hmmu_pkg::BYTE_OPEN;
    if (a >= hmmu_pkg::ADDR_UNUSED_LO && a <= hmmu_pkg::ADDR_UNUSED_HI)
      return hmmu_pkg::BYTE_OPEN;
    return mem_img[a];
  endfunction

  function automatic void poke_bus(logic [15:0] a, logic [7:0] v);
    logic [15:0] src;
    if (a < hmmu_pkg::ADDR_VRAM) return;
    if (a >= hmmu_pkg::ADDR_UNUSED_LO && a <= hmmu_pkg::ADDR_UNUSED_HI) return;
    if (a == hmmu_pkg::ADDR_LY) return;
    if (a >= hmmu_pkg::ADDR_ECHO_LO && a < hmmu_pkg::ADDR_OAM) begin
      mem_img[a] = v;
      mem_img[a - hmmu_pkg::ECHO_OFFSET] = v;
      return;
    end
    if (a == hmmu_pkg::ADDR_JOYP) begin
      strobe_seen = 1'b1;
      strobe_val = v;
    end else if (a == hmmu_pkg::ADDR_DMA) begin
      // copy goes through the read rules, overlay included
      src = {v, 8'h00};
      for (int i = 0; i < hmmu_pkg::DMA_LENGTH; i++) begin
        mem_img[hmmu_pkg::ADDR_OAM + 16'(i)] = peek_bus(src + 16'(i));
      end
    end
    mem_img[a] = v;
  endfunction

  function automatic beat_t decode_access(req_t it);
    beat_t       b;
    logic [15:0] nxt;
    nxt = it.addr + 16'd1;
    pad_now = it.pad;
    exit_seen = 1'b0;
    strobe_seen = 1'b0;
    strobe_val = 8'h00;
    b.read_data = 16'h0000;
    case (it.cmd)
      hmmu_pkg::CMD_RD_BYTE: b.read_data = {8'h00, peek_bus(it.addr)};
      hmmu_pkg::CMD_WR_BYTE: poke_bus(it.addr, it.data[7:0]);
      hmmu_pkg::CMD_RD_WORD: begin
        b.read_data[7:0]  = peek_bus(it.addr);
        b.read_data[15:8] = peek_bus(nxt);
      end
      hmmu_pkg::CMD_WR_WORD: begin
        poke_bus(it.addr, it.data[7:0]);
        poke_bus(nxt, it.data[15:8]);
      end
      hmmu_pkg::CMD_BOOT_LOAD: begin
        if (it.addr < hmmu_pkg::BOOT_LIMIT)
          boot_img[it.addr[hmmu_pkg::BOOT_AW-1:0]] = it.data[7:0];
        overlay_armed = 1'b1;
      end
      default: ;
    endcase
    b.joypad_strobe = strobe_seen;
    b.joypad_value  = strobe_seen ? strobe_val : 8'h00;
    b.boot_exited   = exit_seen;
    return b;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // hold the beat until taken; valid stays high across back-to-back beats
  task automatic offer(req_t it);
    req_ch.valid        <= 1'b1;
    req_ch.command      <= it.cmd;
    req_ch.bus_address  <= it.addr;
    req_ch.write_data   <= it.data;
    req_ch.joypad_state <= it.pad;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_count <= sent_count + 1;
  endtask

  task automatic idle_req(int n);
    req_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // stimulus and prediction
  initial begin
    dir_row_t row;
    req_t     it;
    beat_t    got;
    int       n;

    rst = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.command      = hmmu_pkg::CMD_RD_BYTE;
    req_ch.bus_address  = 16'h0000;
    req_ch.write_data   = 16'h0000;
    req_ch.joypad_state = 8'h00;

    for (int a = 0; a < 65536; a++) mem_img[a] = 8'h00;
    for (int a = 0; a < hmmu_pkg::BOOT_SIZE; a++) boot_img[a] = 8'h00;
    overlay_armed = 1'b0;
    mem_img[16'hFF00] = 8'hFF; mem_img[16'hFF04] = 8'hAF; mem_img[16'hFF07] = 8'hF8;
    mem_img[16'hFF0F] = 8'hE0; mem_img[16'hFF10] = 8'h80; mem_img[16'hFF11] = 8'hBF;
    mem_img[16'hFF12] = 8'hF3; mem_img[16'hFF14] = 8'hBF; mem_img[16'hFF16] = 8'h3F;
    mem_img[16'hFF19] = 8'hBF; mem_img[16'hFF1A] = 8'h7F; mem_img[16'hFF1B] = 8'hFF;
    mem_img[16'hFF1C] = 8'h9F; mem_img[16'hFF1E] = 8'hBF; mem_img[16'hFF1F] = 8'hFF;
    mem_img[16'hFF20] = 8'hFF; mem_img[16'hFF23] = 8'hBF; mem_img[16'hFF24] = 8'h77;
    mem_img[16'hFF25] = 8'hF3; mem_img[16'hFF26] = 8'hF1; mem_img[16'hFF40] = 8'h91;
    mem_img[16'hFF47] = 8'hFC; mem_img[16'hFF48] = 8'hFF; mem_img[16'hFF49] = 8'hFF;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIR_ROWS; k++) begin
      row = DIRECTED[k];
      it.cmd  = row.cmd;
      it.addr = row.addr;
      it.data = row.data;
      it.pad  = row.pad;
      if ($urandom_range(99) < IDLE_PCT) idle_req($urandom_range(1, 5));
      offer(it);
      got = decode_access(it);
      if (row.typed) begin
        got.read_data     = row.rd;
        got.joypad_strobe = row.strb;
        got.joypad_value  = row.jv;
        got.boot_exited   = row.ex;
      end
      results_due.push_back(got);
    end

    n = DIR_ROWS;
    for (int k = 0; k < RAND_ITEMS; k++) begin
      it.data = 16'($urandom);
      it.pad  = 8'($urandom);
      case ($urandom_range(8))
        0:       it.addr = 16'($urandom_range(16'h011F));
        1:       it.addr = $urandom_range(1) ? hmmu_pkg::ADDR_BOOT_EXIT
                                             : hmmu_pkg::ADDR_BOOT_EXIT - 16'd1;
        2:       it.addr = WRAM_BASES[$urandom_range(3)] + 16'($urandom_range(15));
        3:       it.addr = ECHO_BASES[$urandom_range(1)] + 16'($urandom_range(15));
        4:       it.addr = hmmu_pkg::ADDR_OAM + 16'($urandom_range(16'h00FF));
        5:       it.addr = hmmu_pkg::ADDR_JOYP + 16'($urandom_range(16'h004F));
        6:       it.addr = 16'hFF80 + 16'($urandom_range(16'h007F));
        default: it.addr = 16'($urandom);
      endcase
      case ($urandom_range(99)) inside
        [0:29]:  it.cmd = hmmu_pkg::CMD_RD_BYTE;
        [30:51]: it.cmd = hmmu_pkg::CMD_WR_BYTE;
        [52:65]: it.cmd = hmmu_pkg::CMD_RD_WORD;
        [66:77]: it.cmd = hmmu_pkg::CMD_WR_WORD;
        [78:87]: begin
          it.cmd  = hmmu_pkg::CMD_BOOT_LOAD;
          it.addr = ($urandom_range(9) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(hmmu_pkg::BOOT_SIZE - 1));
        end
        [88:91]: it.cmd = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        default: begin
          it.cmd  = hmmu_pkg::CMD_WR_BYTE;
          it.addr = hmmu_pkg::ADDR_DMA;
          it.data[7:0] = ($urandom_range(2) == 0) ? 8'($urandom)
                                                  : DMA_PAGES[$urandom_range(7)];
        end
      endcase

      if (n == PAUSE_AT) begin
        req_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
      end else if ((n < CALM_LO || n >= CALM_HI) && $urandom_range(99) < IDLE_PCT) begin
        idle_req($urandom_range(1, 6));
      end
      offer(it);
      results_due.push_back(decode_access(it));
      n++;
    end

    req_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) $display("handheld_memory_map_unit_core regression: pass");
    else $display("handheld_memory_map_unit_core regression: fail");
    $finish;
  end

  // response side: check each beat, drive ready with random stalls and one long hold
  initial begin
    beat_t want;
    int    hold_left;
    bit    hold_done;

    hold_left = 0;
    hold_done = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("beat with nothing due", rsp_ch.read_data, 16'h0000);
        end else begin
          want = results_due.pop_front();
          if (rsp_ch.read_data !== want.read_data)
            report_mismatch("read_data", rsp_ch.read_data, want.read_data);
          if (rsp_ch.joypad_strobe !== want.joypad_strobe)
            report_mismatch("joypad_strobe", 16'(rsp_ch.joypad_strobe),
                            16'(want.joypad_strobe));
          if (rsp_ch.joypad_value !== want.joypad_value)
            report_mismatch("joypad_value", 16'(rsp_ch.joypad_value),
                            16'(want.joypad_value));
          if (rsp_ch.boot_exited !== want.boot_exited)
            report_mismatch("boot_exited", 16'(rsp_ch.boot_exited), 16'(want.boot_exited));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && sent_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        rsp_ch.ready <= 1'b0;
      end else if (sent_count >= CALM_LO && sent_count < CALM_HI) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: too long without a beat on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("handheld_memory_map_unit_core regression: fail");
    $finish;
  end

endmodule

@@ handheld_memory_map_unit_core.f @@
+incdir+rtl/core
rtl/core/hmmu_pkg.sv
rtl/core/hmmu_if.sv
rtl/core/hmmu_ram.sv
rtl/core/hmmu_ctrl.sv
rtl/core/hmmu_datapath.sv
rtl/core/handheld_memory_map_unit_core.sv
rtl/core/hmmu_checker.sv
tb/tb_top.sv
